// File: rtl/dcpc_pkg.sv
// Shared types, register codes and helpers of the display pixel compositor.
// Depends on nothing; every other file of the block imports it.
package dcpc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] HalfAlpha = 8'h80;
  localparam logic [7:0] FullAlpha = 8'hff;

  typedef enum logic [2:0] {
    FMT_CT32     = 3'd0,
    FMT_CT24     = 3'd1,
    FMT_CT16     = 3'd2,
    FMT_CT16S    = 3'd3,
    FMT_PACKED24 = 3'd4,
    FMT_GX16     = 3'd5,
    FMT_ZERO     = 3'd6
  } fmt_e;

  typedef enum logic [2:0] {
    OP_NONE        = 3'd0,
    OP_RGB         = 3'd1,
    OP_RGBA        = 3'd2,
    OP_ALPHA       = 3'd3,
    OP_SBLEND_RGB  = 3'd4,
    OP_SBLEND_RGBA = 3'd5,
    OP_CBLEND_RGB  = 3'd6,
    OP_CBLEND_RGBA = 3'd7
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_C1_FMT      = 3'd0,
    REG_C2_FMT      = 3'd1,
    REG_C1_OP       = 3'd2,
    REG_C2_OP       = 3'd3,
    REG_BLEND_CONST = 3'd4,
    REG_COMPOSE     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    fmt_e       c1_fmt;
    fmt_e       c2_fmt;
    op_e        c1_op;
    logic [1:0] c2_op;
    logic [7:0] blend_const;
    logic       compose;
  } cfg_t;

  // Result of the decode stage: either a finished pixel or the operands of a mix.
  typedef struct packed {
    logic       mix;
    logic [7:0] alpha;
    pix_t       src;
    pix_t       dest;
    logic [7:0] out_a;
    pix_t       res;
  } dec_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

  function automatic pix_t decode1555(input logic [15:0] w);
    pix_t p;
    p.r = widen5(w[4:0]);
    p.g = widen5(w[9:5]);
    p.b = widen5(w[14:10]);
    p.a = w[15] ? HalfAlpha : 8'h00;
    decode1555 = p;
  endfunction

endpackage

// File: rtl/dcpc_if.sv
// Valid/ready channel interfaces of the display pixel compositor.
// Depends on dcpc_pkg for the configuration port widths.
interface dcpc_pix_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic        source_x_odd;
  logic [31:0] dest_pixel;

  modport source (output valid, req_type, first_word, second_word, source_x_odd,
                  dest_pixel, input ready);
  modport sink   (input valid, req_type, first_word, second_word, source_x_odd,
                  dest_pixel, output ready);
endinterface

interface dcpc_pix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink   (input valid, out_pixel, output ready);
endinterface

interface dcpc_cfg_if;
  import dcpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dcpc_decode.sv
// Source decode and operation select of the display pixel compositor.
// Depends on dcpc_pkg; purely combinational, registered by the top level.
module dcpc_decode (
  input  dcpc_pkg::cfg_t cfg_i,
  input  logic           req_type_i,
  input  logic [15:0]    first_word_i,
  input  logic [15:0]    second_word_i,
  input  logic           source_x_odd_i,
  input  logic [31:0]    dest_pixel_i,
  output dcpc_pkg::dec_t dec_o
);
  import dcpc_pkg::*;

  fmt_e       fmt;
  op_e        op;
  pix_t       src;
  pix_t       dest;
  logic [7:0] src_alpha2;
  logic [7:0] keep_a;

  assign fmt  = req_type_i ? cfg_i.c2_fmt : cfg_i.c1_fmt;
  assign op   = req_type_i ? op_e'({1'b0, cfg_i.c2_op}) : cfg_i.c1_op;
  assign dest = pix_t'(dest_pixel_i);

  always_comb begin
    src = '0;
    if (cfg_i.compose) begin
      src = decode1555(first_word_i);
    end else begin
      case (fmt)
        FMT_CT32: begin
          src = {second_word_i[15:8], first_word_i[7:0], first_word_i[15:8],
                 second_word_i[7:0]};
        end
        FMT_CT24: begin
          src = {HalfAlpha, first_word_i[7:0], first_word_i[15:8], second_word_i[7:0]};
        end
        FMT_CT16, FMT_CT16S, FMT_GX16: begin
          src = decode1555(first_word_i);
        end
        FMT_PACKED24: begin
          if (source_x_odd_i) begin
            src = {HalfAlpha, first_word_i[15:8], second_word_i[7:0], second_word_i[15:8]};
          end else begin
            src = {HalfAlpha, first_word_i[7:0], first_word_i[15:8], second_word_i[7:0]};
          end
        end
        default: begin
          src = '0;
        end
      endcase
    end
  end

  // Source alpha is doubled for blending and saturates at full scale.
  assign src_alpha2 = src.a[7] ? FullAlpha : {src.a[6:0], 1'b0};
  assign keep_a     = (op == OP_SBLEND_RGBA) ? src.a : dest.a;

  always_comb begin
    dec_o       = '0;
    dec_o.src   = src;
    dec_o.dest  = dest;
    dec_o.res   = dest;
    dec_o.out_a = dest.a;
    case (op)
      OP_RGB: begin
        dec_o.res = {dest.a, src.r, src.g, src.b};
      end
      OP_RGBA: begin
        dec_o.res = src;
      end
      OP_ALPHA: begin
        dec_o.res = {src.a, dest.r, dest.g, dest.b};
      end
      OP_SBLEND_RGB, OP_SBLEND_RGBA: begin
        if (cfg_i.compose) begin
          // In compose mode the blend degenerates to a select on the mask bit.
          dec_o.res = first_word_i[15] ? {keep_a, src.r, src.g, src.b}
                                       : {keep_a, dest.r, dest.g, dest.b};
        end else begin
          dec_o.mix   = 1'b1;
          dec_o.alpha = src_alpha2;
          dec_o.out_a = keep_a;
        end
      end
      OP_CBLEND_RGB: begin
        dec_o.mix   = 1'b1;
        dec_o.alpha = cfg_i.blend_const;
        dec_o.out_a = dest.a;
      end
      OP_CBLEND_RGBA: begin
        dec_o.mix   = 1'b1;
        dec_o.alpha = cfg_i.blend_const;
        dec_o.out_a = src.a;
      end
      default: begin
        dec_o.res = dest;
      end
    endcase
  end

endmodule

// File: rtl/display_circuit_pixel_compositor_unit.sv
// Top level of the display pixel compositor: configuration registers and the
// decode, multiply and divide pipeline. Depends on dcpc_pkg, dcpc_if, dcpc_decode.
//
// The compositor takes one pixel beat per clock while no stage stalls and returns
// one result beat per input beat, in order. A beat passes the registered stages:
// source decode and operation select, per-channel 8x8 multiplies of the blend, then
// the divide by 255 (done with a reciprocal add and shift) into the output
// register. With the output sink always ready the sustained rate is one pixel
// per cycle; back-pressure stalls only the stages that are full. The
// configuration port is always ready and writes a register in the cycle its
// beat is taken; it must only be written while no pixel is in flight.
module display_circuit_pixel_compositor_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  dcpc_cfg_if.sink       cfg_i,
  dcpc_pix_in_if.sink    px_i,
  dcpc_pix_out_if.source px_o
);
  import dcpc_pkg::*;

  typedef struct packed {
    logic        mix;
    logic [7:0]  out_a;
    logic [15:0] sum_r;
    logic [15:0] sum_g;
    logic [15:0] sum_b;
    pix_t        res;
  } prod_t;

  // Configuration registers.
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c1_fmt      <= FMT_ZERO;
      cfg_q.c2_fmt      <= FMT_ZERO;
      cfg_q.c1_op       <= OP_NONE;
      cfg_q.c2_op       <= 2'd0;
      cfg_q.blend_const <= 8'd0;
      cfg_q.compose     <= 1'b0;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_C1_FMT:      cfg_q.c1_fmt      <= fmt_e'(cfg_i.data[2:0]);
        REG_C2_FMT:      cfg_q.c2_fmt      <= fmt_e'(cfg_i.data[2:0]);
        REG_C1_OP:       cfg_q.c1_op       <= op_e'(cfg_i.data[2:0]);
        REG_C2_OP:       cfg_q.c2_op       <= cfg_i.data[1:0];
        REG_BLEND_CONST: cfg_q.blend_const <= cfg_i.data;
        REG_COMPOSE:     cfg_q.compose     <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Stage handshake: a stage takes a new beat when it is empty or moving on.
  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3;

  assign ready3     = !v3_q || px_o.ready;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign px_i.ready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= px_i.valid;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // Stage 1: decode.
  dec_t dec_d, dec_q;

  dcpc_decode u_decode (
    .cfg_i          (cfg_q),
    .req_type_i     (px_i.req_type),
    .first_word_i   (px_i.first_word),
    .second_word_i  (px_i.second_word),
    .source_x_odd_i (px_i.source_x_odd),
    .dest_pixel_i   (px_i.dest_pixel),
    .dec_o          (dec_d)
  );

  always_ff @(posedge clk_i) begin
    if (px_i.valid && ready1) dec_q <= dec_d;
  end

  // Stage 2: s*a + d*(255-a) + 127 for each channel; the total stays below 2^16.
  prod_t      prod_d, prod_q;
  logic [7:0] inv_a;

  function automatic logic [15:0] mac(input logic [7:0] s, input logic [7:0] d,
                                      input logic [7:0] a, input logic [7:0] ia);
    logic [16:0] acc;
    acc = 17'(s) * 17'(a) + 17'(d) * 17'(ia) + 17'd127;
    mac = acc[15:0];
  endfunction

  assign inv_a = FullAlpha - dec_q.alpha;

  always_comb begin
    prod_d.mix   = dec_q.mix;
    prod_d.out_a = dec_q.out_a;
    prod_d.res   = dec_q.res;
    prod_d.sum_r = mac(dec_q.src.r, dec_q.dest.r, dec_q.alpha, inv_a);
    prod_d.sum_g = mac(dec_q.src.g, dec_q.dest.g, dec_q.alpha, inv_a);
    prod_d.sum_b = mac(dec_q.src.b, dec_q.dest.b, dec_q.alpha, inv_a);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) prod_q <= prod_d;
  end

  // Stage 3: x / 255 as (x + 1 + (x >> 8)) >> 8, exact over the stage 2 range.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'd1 + {8'd0, x[15:8]};
    div255 = t[15:8];
  endfunction

  pix_t out_d, out_q;

  always_comb begin
    if (prod_q.mix) begin
      out_d = {prod_q.out_a, div255(prod_q.sum_r), div255(prod_q.sum_g),
               div255(prod_q.sum_b)};
    end else begin
      out_d = prod_q.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ready3) out_q <= out_d;
  end

  assign px_o.valid     = v3_q;
  assign px_o.out_pixel = out_q;

  // A stalled decode stage keeps its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !ready2 |=> v1_q)
    else $error("decode stage dropped a stalled beat");

  // An empty pipeline always takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !v2_q && !v3_q |-> px_i.ready)
    else $error("empty pipeline refused input");

  // A beat leaving the decode stage lands in the multiply stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ready2 |=> v2_q)
    else $error("beat lost between decode and multiply");

  // Blend sums never exceed 255*255 + 127, which keeps the divide exact.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && prod_q.mix |-> prod_q.sum_r <= 16'd65152 && prod_q.sum_g <= 16'd65152
                           && prod_q.sum_b <= 16'd65152)
    else $error("blend sum out of range");

endmodule
